// ===== hdl/dcid_pkg.sv =====
// ----------------------------------------------------------------------------
// dcid_pkg
// Shared types, register offsets and codes for the display interrupt and
// command decoder.
// ----------------------------------------------------------------------------
package dcid_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // bus-side offsets (22-bit window)
  localparam logic [21:0] OFF_INT_ENABLE = 22'h381008;
  localparam logic [21:0] OFF_INT_PRESET = 22'h381014;
  localparam logic [21:0] OFF_INT_CLEAR  = 22'h381020;
  localparam logic [21:0] OFF_INT_STATUS = 22'h38102c;
  localparam logic [21:0] OFF_CMD_STATUS = 22'h01019c;
  localparam logic [21:0] OFF_CMD_PORT   = 22'h010000;
  localparam logic [21:0] OFF_DONE_LO    = 22'h00102c;
  localparam logic [21:0] OFF_DONE_HI    = 22'h001030;
  localparam logic [21:0] OFF_FG_ENABLE  = 22'h2b008c;
  localparam logic [21:0] OFF_FG_CHSTAT  = 22'h2b009c;
  localparam logic [21:0] OFF_FG_STAMP   = 22'h2b0098;

  // store-side offsets (full 32-bit, decoded targets may exceed window)
  localparam logic [31:0] OFF_DONE_SET_LO = 32'h00001014;
  localparam logic [31:0] OFF_DONE_SET_HI = 32'h00001018;
  localparam logic [31:0] OFF_DONE_CLR_LO = 32'h00001020;
  localparam logic [31:0] OFF_DONE_CLR_HI = 32'h00001024;
  localparam logic [31:0] OFF_TRIGGER     = 32'h000e1014;

  localparam logic [19:0] FG_ENABLE_WORD = OFF_FG_ENABLE[21:2];

  localparam logic [31:0] CMD_IDLE_FULL = 32'h40000000 | 32'h0001ffff;
  localparam logic [31:0] SYNC_BIT      = 32'h00000100;
  localparam int          STAMP_SHIFT   = 14;
  localparam logic [7:0]  OP_WRITE_CODE = 8'h14;
  localparam logic [31:0] SRC_MASK      = 32'h000c8008;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_READ,
    OP_EN_WR,
    OP_INT_CLR,
    OP_INT_PRESET,
    OP_CMD,
    OP_STORE,
    OP_TICK
  } op_t;

  typedef enum logic [2:0] {
    RD_ZERO,
    RD_CMD_STATUS,
    RD_DONE_LO,
    RD_DONE_HI,
    RD_INT_STATUS,
    RD_INT_ENABLE,
    RD_FG_CHSTAT,
    RD_FG_STAMP
  } rsel_t;

  typedef struct packed {
    op_t         op;
    rsel_t       rsel;
    logic [21:0] offset;
    logic [31:0] data;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [3:0]  irq_lines;
    logic        fwd_valid;
    logic [31:0] fwd_offset;
    logic [31:0] fwd_data;
    logic        blit_trigger;
  } res_t;

endpackage

// ===== hdl/dcid_front.sv =====
// ----------------------------------------------------------------------------
// dcid_front
// Accepts bus items and classifies them into operations and read selects.
// ----------------------------------------------------------------------------
module dcid_front (
  input  logic              push,
  input  logic              q_full,
  input  logic [1:0]        kind,
  input  logic [21:0]       offset,
  input  logic [31:0]       data,
  output logic              q_write,
  output dcid_pkg::item_t   q_item
);
  import dcid_pkg::*;

  op_t   op;
  rsel_t rsel;

  always_comb begin
    rsel = RD_ZERO;
    case (offset)
      OFF_CMD_STATUS: rsel = RD_CMD_STATUS;
      OFF_DONE_LO:    rsel = RD_DONE_LO;
      OFF_DONE_HI:    rsel = RD_DONE_HI;
      OFF_INT_STATUS: rsel = RD_INT_STATUS;
      OFF_INT_ENABLE: rsel = RD_INT_ENABLE;
      OFF_FG_CHSTAT:  rsel = RD_FG_CHSTAT;
      OFF_FG_STAMP:   rsel = RD_FG_STAMP;
      default:        rsel = RD_ZERO;
    endcase
  end

  always_comb begin
    op = OP_NOP;
    case (kind)
      KIND_READ: op = OP_READ;
      KIND_WRITE: begin
        case (offset)
          OFF_INT_ENABLE: op = OP_EN_WR;
          OFF_INT_CLEAR:  op = OP_INT_CLR;
          OFF_INT_PRESET: op = OP_INT_PRESET;
          OFF_CMD_PORT:   op = OP_CMD;
          default:        op = OP_STORE;
        endcase
      end
      KIND_TICK: op = OP_TICK;
      default:   op = OP_NOP;
    endcase
  end

  assign q_write       = push & ~q_full;
  assign q_item.op     = op;
  assign q_item.rsel   = rsel;
  assign q_item.offset = offset;
  assign q_item.data   = data;

endmodule

// ===== hdl/dcid_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// dcid_cmd_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module dcid_cmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  dcid_pkg::item_t wr_item,
  output logic            full,
  output logic            valid,
  input  logic            take,
  output dcid_pkg::item_t rd_item
);
  import dcid_pkg::*;

  item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  logic do_wr;
  logic do_rd;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign do_wr   = wr & ~full;
  assign do_rd   = take & valid;
  assign rd_item = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/dcid_back.sv =====
// ----------------------------------------------------------------------------
// dcid_back
// Executes classified items against the interrupt, completion and command
// decoder state, and queues one result per item.
// ----------------------------------------------------------------------------
module dcid_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  dcid_pkg::item_t q_item,
  output logic            q_take,
  input  logic            pop,
  output logic            empty,
  output dcid_pkg::res_t  res_head
);
  import dcid_pkg::*;

  logic [31:0] irq_status, irq_status_next;
  logic [31:0] irq_enable, irq_enable_next;
  logic [31:0] frame_counter, frame_counter_next;
  logic [15:0] words_left, words_left_next;
  logic [31:0] target_offset, target_offset_next;
  logic        expect_offset, expect_offset_next;
  logic [31:0] done_status_low, done_status_low_next;
  logic [31:0] done_status_high, done_status_high_next;
  logic        framegen_on, framegen_on_next;

  res_t        res;
  logic        sw_en;
  logic [31:0] sw_off;
  logic [31:0] sw_val;
  logic [31:0] lines_src;

  res_t              rq [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rq_wptr;
  logic [QPTR_W-1:0] rq_rptr;
  logic [QCNT_W-1:0] rq_count;
  logic              exec;
  logic              rq_rd;

  assign exec     = q_valid && (rq_count != QCNT_W'(QUEUE_DEPTH));
  assign q_take   = exec;
  assign empty    = (rq_count == '0);
  assign rq_rd    = pop & ~empty;
  assign res_head = rq[rq_rptr];

  always_comb begin
    irq_status_next       = irq_status;
    irq_enable_next       = irq_enable;
    frame_counter_next    = frame_counter;
    words_left_next       = words_left;
    target_offset_next    = target_offset;
    expect_offset_next    = expect_offset;
    done_status_low_next  = done_status_low;
    done_status_high_next = done_status_high;
    framegen_on_next      = framegen_on;
    res                   = '0;
    sw_en                 = 1'b0;
    sw_off                = '0;
    sw_val                = q_item.data;

    case (q_item.op)
      OP_READ: begin
        case (q_item.rsel)
          RD_CMD_STATUS: res.read_data = CMD_IDLE_FULL;
          RD_DONE_LO:    res.read_data = done_status_low;
          RD_DONE_HI:    res.read_data = done_status_high;
          RD_INT_STATUS: res.read_data = irq_status;
          RD_INT_ENABLE: res.read_data = irq_enable;
          RD_FG_CHSTAT:  res.read_data = framegen_on ? SYNC_BIT : '0;
          RD_FG_STAMP:   res.read_data = frame_counter << STAMP_SHIFT;
          default:       res.read_data = '0;
        endcase
      end
      OP_EN_WR:      irq_enable_next = q_item.data;
      OP_INT_CLR:    irq_status_next = irq_status & ~q_item.data;
      OP_INT_PRESET: irq_status_next = irq_status | q_item.data;
      OP_CMD: begin
        if (words_left == '0 && !expect_offset) begin
          if (q_item.data[31:24] == OP_WRITE_CODE) begin
            words_left_next    = q_item.data[15:0];
            expect_offset_next = 1'b1;
          end
        end else if (expect_offset) begin
          target_offset_next = q_item.data;
          expect_offset_next = 1'b0;
        end else begin
          sw_en              = 1'b1;
          sw_off             = target_offset;
          target_offset_next = target_offset + 32'd4;
          words_left_next    = words_left - 16'd1;
        end
      end
      OP_STORE: begin
        sw_en  = 1'b1;
        sw_off = {10'd0, q_item.offset};
      end
      OP_TICK: begin
        if ((irq_enable & SRC_MASK) != '0) begin
          frame_counter_next = frame_counter + 32'd1;
          irq_status_next    = irq_status | (irq_enable & SRC_MASK);
        end
      end
      default: ;
    endcase

    if (sw_en) begin
      case (sw_off)
        OFF_DONE_SET_LO: done_status_low_next  = done_status_low | sw_val;
        OFF_DONE_SET_HI: done_status_high_next = done_status_high | sw_val;
        OFF_DONE_CLR_LO: done_status_low_next  = done_status_low & ~sw_val;
        OFF_DONE_CLR_HI: done_status_high_next = done_status_high & ~sw_val;
        default: begin
          if (sw_off[31:22] == '0 && sw_off[21:2] == FG_ENABLE_WORD) begin
            framegen_on_next = sw_val[0];
          end
          res.fwd_valid    = 1'b1;
          res.fwd_offset   = sw_off;
          res.fwd_data     = sw_val;
          res.blit_trigger = (sw_off == OFF_TRIGGER);
        end
      endcase
    end

    lines_src     = irq_status_next & irq_enable_next;
    res.irq_lines = {lines_src[19], lines_src[18], lines_src[15], lines_src[3]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_status       <= '0;
      irq_enable       <= '0;
      frame_counter    <= '0;
      words_left       <= '0;
      target_offset    <= '0;
      expect_offset    <= 1'b0;
      done_status_low  <= '0;
      done_status_high <= '0;
      framegen_on      <= 1'b0;
    end else if (exec) begin
      irq_status       <= irq_status_next;
      irq_enable       <= irq_enable_next;
      frame_counter    <= frame_counter_next;
      words_left       <= words_left_next;
      target_offset    <= target_offset_next;
      expect_offset    <= expect_offset_next;
      done_status_low  <= done_status_low_next;
      done_status_high <= done_status_high_next;
      framegen_on      <= framegen_on_next;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      rq[rq_wptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wptr  <= '0;
      rq_rptr  <= '0;
      rq_count <= '0;
    end else begin
      if (exec) begin
        rq_wptr <= (rq_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rq_wptr + 1'b1;
      end
      if (rq_rd) begin
        rq_rptr <= (rq_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rq_rptr + 1'b1;
      end
      if (exec && !rq_rd) begin
        rq_count <= rq_count + 1'b1;
      end else if (rq_rd && !exec) begin
        rq_count <= rq_count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/display_ctrl_irq_and_cmd_decoder.sv =====
// ----------------------------------------------------------------------------
// display_ctrl_irq_and_cmd_decoder
// Display interrupt status/enable, frame tick counter, completion words and
// command-word decoder behind queue-style push/pop ports. One item is taken
// per cycle while the queues have room and gives exactly one result; an
// item is written to the command queue and its result to the result queue
// before the result can be popped. The sustained rate of one item per cycle,
// when no queue stalls, is set by the single execute stage in the back end,
// which updates all state for one item at once; two-entry queues between
// front and back and on the result side let either side stall independently.
// ----------------------------------------------------------------------------
module display_ctrl_irq_and_cmd_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind,
  input  logic [21:0] offset,
  input  logic [31:0] data,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] read_data,
  output logic [3:0]  irq_lines,
  output logic        fwd_valid,
  output logic [31:0] fwd_offset,
  output logic [31:0] fwd_data,
  output logic        blit_trigger
);
  import dcid_pkg::*;

  logic  q_write;
  item_t q_wr_item;
  logic  q_valid;
  logic  q_take;
  item_t q_rd_item;
  res_t  res_head;

  dcid_front u_front (
    .push    (push),
    .q_full  (full),
    .kind    (kind),
    .offset  (offset),
    .data    (data),
    .q_write (q_write),
    .q_item  (q_wr_item)
  );

  dcid_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_write),
    .wr_item (q_wr_item),
    .full    (full),
    .valid   (q_valid),
    .take    (q_take),
    .rd_item (q_rd_item)
  );

  dcid_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_rd_item),
    .q_take   (q_take),
    .pop      (pop),
    .empty    (empty),
    .res_head (res_head)
  );

  assign read_data    = res_head.read_data;
  assign irq_lines    = res_head.irq_lines;
  assign fwd_valid    = res_head.fwd_valid;
  assign fwd_offset   = res_head.fwd_offset;
  assign fwd_data     = res_head.fwd_data;
  assign blit_trigger = res_head.blit_trigger;

  assert property (@(posedge clk) disable iff (rst)
    push && !full |=> q_valid)
    else $error("accepted item missing from queue");

  assert property (@(posedge clk) disable iff (rst)
    !empty && !fwd_valid |-> fwd_offset == '0 && fwd_data == '0 && !blit_trigger)
    else $error("forward fields set without forward");

  assert property (@(posedge clk) disable iff (rst)
    !empty && read_data != '0 |-> !fwd_valid)
    else $error("read result also forwards a write");

endmodule

// ===== verif/display_ctrl_irq_and_cmd_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// display_ctrl_irq_and_cmd_decoder_tb
// Drives bus reads, bus writes and frame ticks into the push side, computes
// the register and command-decoder outcome of each transfer in a local
// model, and compares every popped result field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module display_ctrl_irq_and_cmd_decoder_tb;
  import dcid_pkg::*;

  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam logic [7:0] OP_SYNC_CODE = 8'h20;
  localparam int         CYCLE_LIMIT  = 200000;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [1:0]  kind;
  logic [21:0] offset;
  logic [31:0] data;
  logic        empty;
  logic        pop;
  logic [31:0] read_data;
  logic [3:0]  irq_lines;
  logic        fwd_valid;
  logic [31:0] fwd_offset;
  logic [31:0] fwd_data;
  logic        blit_trigger;

  display_ctrl_irq_and_cmd_decoder dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .kind(kind), .offset(offset),
    .data(data), .empty(empty), .pop(pop), .read_data(read_data),
    .irq_lines(irq_lines), .fwd_valid(fwd_valid), .fwd_offset(fwd_offset),
    .fwd_data(fwd_data), .blit_trigger(blit_trigger)
  );

  // model state
  logic [31:0] irq_status_q;
  logic [31:0] irq_enable_q;
  logic [31:0] frame_count_q;
  logic [15:0] cmd_words_left;
  logic [31:0] cmd_target_q;
  logic        cmd_want_offset;
  logic [31:0] done_lo_q;
  logic [31:0] done_hi_q;
  logic        framegen_q;

  res_t awaited_results[$];
  int   err_count;
  int   items_sent;
  int   cycle_count;
  int   send_gap;
  int   recv_gap;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // store-side write: completion words or forward
  function automatic void store_access(input logic [31:0] off, input logic [31:0] val,
                                       inout res_t r);
    case (off)
      OFF_DONE_SET_LO: done_lo_q = done_lo_q | val;
      OFF_DONE_SET_HI: done_hi_q = done_hi_q | val;
      OFF_DONE_CLR_LO: done_lo_q = done_lo_q & ~val;
      OFF_DONE_CLR_HI: done_hi_q = done_hi_q & ~val;
      default: begin
        if (off[31:22] == '0 && off[21:2] == FG_ENABLE_WORD) framegen_q = val[0];
        r.fwd_valid    = 1'b1;
        r.fwd_offset   = off;
        r.fwd_data     = val;
        r.blit_trigger = (off == OFF_TRIGGER);
      end
    endcase
  endfunction

  function automatic void cmd_word(input logic [31:0] w, inout res_t r);
    if (cmd_words_left == '0 && !cmd_want_offset) begin
      if (w[31:24] == OP_WRITE_CODE) begin
        cmd_words_left  = w[15:0];
        cmd_want_offset = 1'b1;
      end
    end else if (cmd_want_offset) begin
      cmd_target_q    = w;
      cmd_want_offset = 1'b0;
    end else begin
      store_access(cmd_target_q, w, r);
      cmd_target_q   = cmd_target_q + 32'd4;
      cmd_words_left = cmd_words_left - 16'd1;
    end
  endfunction

  function automatic res_t decode_access(input logic [1:0] k, input logic [21:0] off,
                                         input logic [31:0] d);
    res_t        r;
    logic [31:0] act;
    r = '0;
    case (k)
      KIND_READ: begin
        case (off)
          OFF_CMD_STATUS: r.read_data = CMD_IDLE_FULL;
          OFF_DONE_LO:    r.read_data = done_lo_q;
          OFF_DONE_HI:    r.read_data = done_hi_q;
          OFF_INT_STATUS: r.read_data = irq_status_q;
          OFF_INT_ENABLE: r.read_data = irq_enable_q;
          OFF_FG_CHSTAT:  r.read_data = framegen_q ? SYNC_BIT : 32'd0;
          OFF_FG_STAMP:   r.read_data = frame_count_q << STAMP_SHIFT;
          default:        r.read_data = 32'd0;
        endcase
      end
      KIND_WRITE: begin
        case (off)
          OFF_INT_ENABLE: irq_enable_q = d;
          OFF_INT_CLEAR:  irq_status_q = irq_status_q & ~d;
          OFF_INT_PRESET: irq_status_q = irq_status_q | d;
          OFF_CMD_PORT:   cmd_word(d, r);
          default:        store_access({10'd0, off}, d, r);
        endcase
      end
      KIND_TICK: begin
        if ((irq_enable_q & SRC_MASK) != '0) begin
          frame_count_q = frame_count_q + 32'd1;
          irq_status_q  = irq_status_q | (irq_enable_q & SRC_MASK);
        end
      end
      default: ;
    endcase
    act = irq_status_q & irq_enable_q;
    r.irq_lines = {act[19], act[18], act[15], act[3]};
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    err_count++;
  endtask

  task automatic check_result();
    res_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch("unexpected transfer", read_data, 32'd0);
    end else begin
      want = awaited_results.pop_front();
      if (read_data !== want.read_data)
        report_mismatch("read_data", read_data, want.read_data);
      if (irq_lines !== want.irq_lines)
        report_mismatch("irq_lines", 32'(irq_lines), 32'(want.irq_lines));
      if (fwd_valid !== want.fwd_valid)
        report_mismatch("fwd_valid", 32'(fwd_valid), 32'(want.fwd_valid));
      if (fwd_offset !== want.fwd_offset)
        report_mismatch("fwd_offset", fwd_offset, want.fwd_offset);
      if (fwd_data !== want.fwd_data)
        report_mismatch("fwd_data", fwd_data, want.fwd_data);
      if (blit_trigger !== want.blit_trigger)
        report_mismatch("blit_trigger", 32'(blit_trigger), 32'(want.blit_trigger));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) check_result();
  end

  always @(negedge clk) begin
    pop <= !rst && ($urandom_range(99) >= recv_gap);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input logic [1:0] k, input logic [21:0] off,
                           input logic [31:0] d);
    while ($urandom_range(99) < send_gap) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push   <= 1'b1;
    kind   <= k;
    offset <= off;
    data   <= d;
    do @(posedge clk); while (full);
    awaited_results.push_back(decode_access(k, off, d));
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(7))
      0:       return 32'd0;
      1:       return '1;
      2:       return 32'd1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [21:0] random_write_offset();
    case ($urandom_range(9))
      0:       return OFF_INT_ENABLE;
      1:       return OFF_INT_CLEAR;
      2:       return OFF_INT_PRESET;
      3:       return OFF_DONE_SET_LO[21:0];
      4:       return OFF_DONE_SET_HI[21:0];
      5:       return OFF_DONE_CLR_LO[21:0];
      6:       return OFF_DONE_CLR_HI[21:0];
      7:       return OFF_FG_ENABLE | 22'($urandom_range(3));
      8:       return OFF_TRIGGER[21:0];
      default: return 22'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_target();
    case ($urandom_range(9))
      0:       return OFF_TRIGGER;
      1:       return OFF_DONE_SET_LO;
      2:       return OFF_DONE_CLR_HI;
      3:       return {10'd0, OFF_FG_ENABLE} | 32'($urandom_range(3));
      4:       return {10'($urandom_range(1, 1023)), OFF_FG_ENABLE};
      5:       return 32'hfffffff8;
      6:       return {10'd0, OFF_FG_ENABLE} - 32'd4;
      7:       return {10'd0, OFF_INT_ENABLE};
      8:       return {10'd0, 22'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [21:0] random_read_offset();
    case ($urandom_range(8))
      0:       return OFF_CMD_STATUS;
      1:       return OFF_DONE_LO;
      2:       return OFF_DONE_HI;
      3:       return OFF_INT_STATUS;
      4:       return OFF_INT_ENABLE;
      5:       return OFF_FG_CHSTAT;
      6:       return OFF_FG_STAMP;
      default: return 22'($urandom);
    endcase
  endfunction

  task automatic test_irq_block();
    send_item(KIND_WRITE, OFF_INT_ENABLE, '1);
    send_item(KIND_TICK, 22'h3fffff, '1);
    send_item(KIND_READ, OFF_INT_STATUS, 32'd0);
    send_item(KIND_WRITE, OFF_INT_CLEAR, 32'h00080008);
    send_item(KIND_WRITE, OFF_INT_PRESET, 32'h00000008);
    send_item(KIND_READ, OFF_FG_STAMP, 32'd0);
    send_item(KIND_WRITE, OFF_INT_ENABLE, ~SRC_MASK);
    send_item(KIND_TICK, 22'd0, 32'd0);
  endtask

  task automatic test_done_words();
    send_item(KIND_WRITE, OFF_DONE_SET_LO[21:0], '1);
    send_item(KIND_WRITE, OFF_DONE_CLR_HI[21:0], 32'h0000ffff);
    send_item(KIND_READ, OFF_DONE_LO, 32'd0);
    send_item(KIND_READ, OFF_CMD_STATUS, 32'd0);
  endtask

  task automatic test_cmd_decoder();
    send_item(KIND_WRITE, OFF_CMD_PORT, {OP_SYNC_CODE, 24'h000001});
    // zero count
    send_item(KIND_WRITE, OFF_CMD_PORT, {OP_WRITE_CODE, 24'd0});
    send_item(KIND_WRITE, OFF_CMD_PORT, OFF_TRIGGER);
    // target wraps past the top
    send_item(KIND_WRITE, OFF_CMD_PORT, {OP_WRITE_CODE, 8'hff, 16'd2});
    send_item(KIND_WRITE, OFF_CMD_PORT, 32'hfffffffc);
    send_item(KIND_WRITE, OFF_CMD_PORT, 32'hdeadbeef);
    send_item(KIND_WRITE, OFF_CMD_PORT, 32'h12345678);
    // decoded write to the enable only reaches the store
    send_item(KIND_WRITE, OFF_CMD_PORT, {OP_WRITE_CODE, 24'd1});
    send_item(KIND_WRITE, OFF_CMD_PORT, {10'd0, OFF_INT_ENABLE});
    send_item(KIND_WRITE, OFF_CMD_PORT, '1);
    // out-of-window alias of the framegen enable
    send_item(KIND_WRITE, OFF_CMD_PORT, {OP_WRITE_CODE, 24'd1});
    send_item(KIND_WRITE, OFF_CMD_PORT, {10'd1, OFF_FG_ENABLE});
    send_item(KIND_WRITE, OFF_CMD_PORT, 32'd1);
  endtask

  task automatic test_store_forward();
    send_item(KIND_WRITE, OFF_FG_ENABLE | 22'd3, 32'd1);
    send_item(KIND_READ, OFF_FG_CHSTAT, 32'd0);
    send_item(KIND_WRITE, OFF_TRIGGER[21:0], 32'h00000001);
    send_item(KIND_READ, 22'd0, '1);
  endtask

  task automatic test_unused_kind();
    send_item(KIND_UNUSED, 22'h3fffff, '1);
  endtask

  task automatic test_random_traffic(input int n_items);
    int          stop_at;
    int          pick;
    int          n;
    int          i;
    logic [31:0] w;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        n = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 4);
        send_item(KIND_WRITE, OFF_CMD_PORT, {OP_WRITE_CODE, 8'($urandom), 16'(n)});
        send_item(KIND_WRITE, OFF_CMD_PORT, random_target());
        if ($urandom_range(11) == 0) n = $urandom_range(n);
        for (i = 0; i < n; i++) send_item(KIND_WRITE, OFF_CMD_PORT, random_word());
      end else if (pick < 45) begin
        send_item(KIND_READ, random_read_offset(), $urandom);
      end else if (pick < 57) begin
        send_item(KIND_TICK, 22'($urandom), $urandom);
      end else if (pick < 65) begin
        w = $urandom_range(1) ? (random_word() & SRC_MASK) : random_word();
        send_item(KIND_WRITE, OFF_INT_ENABLE, w);
      end else if (pick < 82) begin
        send_item(KIND_WRITE, random_write_offset(), random_word());
      end else if (pick < 92) begin
        w = $urandom;
        if (w[31:24] == OP_WRITE_CODE || $urandom_range(3) == 0) w[31:24] = OP_SYNC_CODE;
        send_item(KIND_WRITE, OFF_CMD_PORT, w);
      end else begin
        send_item(2'($urandom), 22'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    rst             = 1'b1;
    push            = 1'b0;
    pop             = 1'b0;
    kind            = KIND_READ;
    offset          = '0;
    data            = '0;
    irq_status_q    = '0;
    irq_enable_q    = '0;
    frame_count_q   = '0;
    cmd_words_left  = '0;
    cmd_target_q    = '0;
    cmd_want_offset = 1'b0;
    done_lo_q       = '0;
    done_hi_q       = '0;
    framegen_q      = 1'b0;
    err_count       = 0;
    items_sent      = 0;
    cycle_count     = 0;
    send_gap        = 28;
    recv_gap        = 85;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_irq_block();
    test_done_words();
    test_cmd_decoder();
    test_store_forward();
    test_unused_kind();
    test_random_traffic(360);
    send_gap = 85;
    recv_gap = 28;
    test_random_traffic(360);
    send_gap = 0;
    recv_gap = 0;
    test_random_traffic(360);

    push <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
